// ===== hw/rtl/cdt_pkg.sv =====
// Package for the countdown timer with overtime display.
// Holds the transfer structs, function and format codes and the sizes
// shared by the control, formatting and top-level modules.
package cdt_pkg;

  // field widths
  localparam int FUNC_W    = 3;
  localparam int SETV_W    = 13;
  localparam int STEP_W    = 12;
  localparam int REM_W     = 20;
  localparam int EXT_W     = REM_W + 1;
  localparam int MAG_W     = 19;
  localparam int HOURS_W   = 7;
  localparam int MINUTES_W = 7;
  localparam int SECS_W    = 6;
  localparam int FMT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLUS  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MINUS = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_START = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HOLD  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd5;

  // display format codes
  localparam logic [FMT_W-1:0] FMT_MSS  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_PMSS = 2'd1;
  localparam logic [FMT_W-1:0] FMT_PMM  = 2'd2;
  localparam logic [FMT_W-1:0] FMT_PHMS = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;

  // reset values and limits
  localparam logic [STEP_W-1:0] STEP_RESET  = 12'd30;
  localparam logic [SETV_W-1:0] SET_CEILING = 13'd5999;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SETV_W-1:0] set_value;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 running;
    logic                 alarm;
    logic [FMT_W-1:0]     format;
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECS_W-1:0]    seconds_shown;
    logic                 thin_font;
  } out_item_t;

  // status flags that ride along with the count through the display pipeline
  typedef struct packed {
    logic             accepted;
    logic             running;
    logic             alarm;
    logic [FMT_W-1:0] format;
    logic             thin;
  } cdt_flags_t;

  // first stage payload: flags and magnitude of the count
  typedef struct packed {
    cdt_flags_t       flags;
    logic [MAG_W-1:0] mag;
  } cdt_stage1_t;

endpackage

// ===== hw/rtl/cdt_ctrl.sv =====
// Timer control: configuration registers, count state and first stage.
// Updates the count on each accepted item and registers flags and magnitude.
// Depends on cdt_pkg.
module cdt_ctrl
  import cdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 s1_valid,
  input  logic                 s1_ready,
  output cdt_stage1_t          s1_data
);

  localparam logic signed [EXT_W-1:0] OVT_FLOOR  = -21'sd359999;
  localparam logic signed [EXT_W-1:0] THIN_LIMIT = -21'sd600;
  localparam logic signed [EXT_W-1:0] EXT_ZERO   = 21'sd0;
  localparam logic [MAG_W-1:0]        MAG_HOUR   = 19'd3600;
  localparam logic [MAG_W-1:0]        MAG_TENMIN = 19'd600;

  logic [STEP_W-1:0]  step_r;
  logic [SETV_W-1:0]  max_r;
  logic [REM_W-1:0]   rem_r;
  logic               run_r;
  logic               thin_r;
  logic               s1_valid_r;
  cdt_stage1_t        s1_data_r;

  logic                    in_fire;
  logic [SETV_W-1:0]       cap;
  logic signed [EXT_W-1:0] rem_ext;
  logic signed [EXT_W-1:0] cap_ext;
  logic signed [EXT_W-1:0] step_ext;
  logic signed [EXT_W-1:0] setv_ext;
  logic signed [EXT_W-1:0] sum;
  logic signed [EXT_W-1:0] diff;
  logic signed [EXT_W-1:0] rem_nxt;
  logic signed [EXT_W-1:0] neg_rem;
  logic                    run_nxt;
  logic                    thin_nxt;
  logic                    acc;
  logic                    alarm;
  logic                    rem_nz;
  logic [MAG_W-1:0]        mag;
  logic [FMT_W-1:0]        fmt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid_r || s1_ready;
  assign in_fire   = in_valid && in_ready;
  assign s1_valid  = s1_valid_r;
  assign s1_data   = s1_data_r;

  // operands widened to one spare bit
  assign cap      = (max_r < SET_CEILING) ? max_r : SET_CEILING;
  assign rem_ext  = {rem_r[REM_W-1], rem_r};
  assign cap_ext  = {{(EXT_W-SETV_W){1'b0}}, cap};
  assign step_ext = {{(EXT_W-STEP_W){1'b0}}, step_r};
  assign setv_ext = {{(EXT_W-SETV_W){1'b0}}, in_data.set_value};
  assign sum      = rem_ext + step_ext;
  assign diff     = rem_ext - step_ext;
  assign rem_nz   = (rem_r != '0);

  // next count and control state
  always_comb begin
    rem_nxt = rem_ext;
    run_nxt = run_r;
    acc     = 1'b0;
    alarm   = 1'b0;
    thin_nxt = thin_r;
    case (in_data.func)
      FUNC_TICK: begin
        if (run_r) begin
          if (rem_ext > OVT_FLOOR) rem_nxt = rem_ext - 21'sd1;
          alarm = (rem_nxt == EXT_ZERO);
        end
      end
      FUNC_PLUS: begin
        if (!run_r) rem_nxt = (sum > cap_ext) ? cap_ext : sum;
      end
      FUNC_MINUS: begin
        if (!run_r) rem_nxt = (diff < EXT_ZERO) ? EXT_ZERO : diff;
      end
      FUNC_START: begin
        if (rem_nz) begin
          run_nxt = !run_r;
          acc     = 1'b1;
        end
      end
      FUNC_HOLD: begin
        if (run_r || rem_nz) begin
          rem_nxt  = EXT_ZERO;
          run_nxt  = 1'b0;
          thin_nxt = 1'b0;
          acc      = 1'b1;
        end
      end
      FUNC_SET: begin
        rem_nxt = (setv_ext > cap_ext) ? cap_ext : setv_ext;
      end
      default: begin
        rem_nxt = rem_ext;
      end
    endcase
    if (rem_nxt <= THIN_LIMIT) thin_nxt = 1'b1;
  end

  // magnitude and format of the new count
  assign neg_rem = -rem_nxt;
  assign mag     = rem_nxt[EXT_W-1] ? neg_rem[MAG_W-1:0] : rem_nxt[MAG_W-1:0];

  always_comb begin
    if (!rem_nxt[EXT_W-1]) begin
      fmt = FMT_MSS;
    end else if (mag >= MAG_HOUR) begin
      fmt = FMT_PHMS;
    end else if (mag >= MAG_TENMIN) begin
      fmt = FMT_PMM;
    end else begin
      fmt = FMT_PMSS;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_RESET;
      max_r      <= SET_CEILING;
      rem_r      <= '0;
      run_r      <= 1'b0;
      thin_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STEP) step_r <= cfg_data[STEP_W-1:0];
        if (cfg_index == CFG_MAX)  max_r  <= cfg_data[SETV_W-1:0];
      end
      if (in_fire) begin
        rem_r  <= rem_nxt[REM_W-1:0];
        run_r  <= run_nxt;
        thin_r <= thin_nxt;
      end
      if (in_ready) s1_valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r.flags.accepted <= acc;
      s1_data_r.flags.running  <= run_nxt;
      s1_data_r.flags.alarm    <= alarm;
      s1_data_r.flags.format   <= fmt;
      s1_data_r.flags.thin     <= thin_nxt;
      s1_data_r.mag            <= mag;
    end
  end

endmodule

// ===== hw/rtl/cdt_fmt.sv =====
// Display formatting pipeline: splits the count magnitude into hours,
// minutes and seconds by reciprocal multiplies with one correction step each.
// Depends on cdt_pkg; the last stage is the result register.
module cdt_fmt
  import cdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  output logic        s1_ready,
  input  cdt_stage1_t s1_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int VAL_W = 13;
  // floor(2^18 / 225) and floor(2^16 / 60), both underestimate by under one
  localparam logic [10:0]      HOUR_RECIP = 11'd1165;
  localparam logic [10:0]      MIN_RECIP  = 11'd1092;
  localparam logic [MAG_W-1:0] HOUR_SECS  = 19'd3600;
  localparam logic [VAL_W-1:0] MIN_SECS   = 13'd60;

  logic v2_r, v3_r, v4_r, v5_r;
  logic rdy2, rdy3, rdy4, rdy5;

  // stage 2: hours estimate
  cdt_flags_t         f2_r;
  logic [MAG_W-1:0]   mag2_r;
  logic [HOURS_W-1:0] hq2_r;
  // stage 3: hours corrected, remainder selected
  cdt_flags_t         f3_r;
  logic [HOURS_W-1:0] hrs3_r;
  logic [VAL_W-1:0]   val3_r;
  // stage 4: minutes estimate
  cdt_flags_t           f4_r;
  logic [HOURS_W-1:0]   hrs4_r;
  logic [VAL_W-1:0]     val4_r;
  logic [MINUTES_W-1:0] mq4_r;
  // stage 5: result register
  out_item_t            out_r;

  logic [25:0]          hprod;
  logic [MAG_W-1:0]     hsub;
  logic [MAG_W-1:0]     hrem;
  logic [HOURS_W-1:0]   hq_fix;
  logic [MAG_W-1:0]     hrem_fix;
  logic [23:0]          mprod;
  logic [VAL_W-1:0]     msub;
  logic [VAL_W-1:0]     mrem;
  logic [MINUTES_W-1:0] mq_fix;
  logic [VAL_W-1:0]     mrem_fix;

  // ready chain, a stage loads when empty or draining
  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;
  assign out_valid = v5_r;
  assign out_data  = out_r;

  // hours = (mag / 16) / 225 via reciprocal
  assign hprod = {11'd0, s1_data.mag[MAG_W-1:4]} * {15'd0, HOUR_RECIP};

  // hours correction
  assign hsub     = {12'd0, hq2_r} * HOUR_SECS;
  assign hrem     = mag2_r - hsub;
  assign hq_fix   = (hrem >= HOUR_SECS) ? hq2_r + 7'd1 : hq2_r;
  assign hrem_fix = (hrem >= HOUR_SECS) ? hrem - HOUR_SECS : hrem;

  // minutes estimate
  assign mprod = {11'd0, val3_r} * {13'd0, MIN_RECIP};

  // minutes correction
  assign msub     = {6'd0, mq4_r} * MIN_SECS;
  assign mrem     = val4_r - msub;
  assign mq_fix   = (mrem >= MIN_SECS) ? mq4_r + 7'd1 : mq4_r;
  assign mrem_fix = (mrem >= MIN_SECS) ? mrem - MIN_SECS : mrem;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      f2_r   <= s1_data.flags;
      mag2_r <= s1_data.mag;
      hq2_r  <= hprod[24:18];
    end
    if (rdy3 && v2_r) begin
      f3_r <= f2_r;
      if (f2_r.format == FMT_PHMS) begin
        hrs3_r <= hq_fix;
        val3_r <= hrem_fix[VAL_W-1:0];
      end else begin
        hrs3_r <= '0;
        val3_r <= mag2_r[VAL_W-1:0];
      end
    end
    if (rdy4 && v3_r) begin
      f4_r   <= f3_r;
      hrs4_r <= hrs3_r;
      val4_r <= val3_r;
      mq4_r  <= mprod[22:16];
    end
    if (rdy5 && v4_r) begin
      out_r.accepted      <= f4_r.accepted;
      out_r.running       <= f4_r.running;
      out_r.alarm         <= f4_r.alarm;
      out_r.format        <= f4_r.format;
      out_r.hours         <= hrs4_r;
      out_r.minutes       <= mq_fix;
      out_r.seconds_shown <= mrem_fix[SECS_W-1:0];
      out_r.thin_font     <= f4_r.thin;
    end
  end

endmodule

// ===== hw/rtl/countdown_timer_with_overtime.sv =====
// Countdown timer with overtime display, top level.
// Input items carry a function code (tick, plus, minus, start/pause, hold,
// set time) and a set value; each accepted item gives exactly one result.
// A result carries the accepted and running flags, the alarm pulse, the
// display format, hours, minutes, seconds and the thin-font flag.
// The configuration port (cfg_index 0 step seconds, 1 maximum set time) is
// always ready; it is to be written only while no item is in flight, which
// the block itself does not enforce. The count is updated when an item is
// accepted and registered with its flags in the first stage; two reciprocal
// multiplies with a correction each then split it into display groups.
// Throughput: one item per cycle while out_ready is high; every pipeline stage holds one item.
// Stall: when out_ready is low the result register holds, stages behind it
// keep filling until full, then in_ready drops.
// Reset: the count, running and thin-font state clear, step becomes 30 and
// the maximum set time 5999, and the pipeline empties.
// Depends on cdt_pkg, cdt_ctrl and cdt_fmt.
module countdown_timer_with_overtime
  import cdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic        s1_valid;
  logic        s1_ready;
  cdt_stage1_t s1_data;

  // count state and first stage
  cdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_data   (s1_data)
  );

  // display formatting and result register
  cdt_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_data   (s1_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/countdown_timer_with_overtime_tb.sv =====
// Testbench for countdown_timer_with_overtime: drives button and tick events,
// predicts every display result in-house and checks each one as it leaves.
// Depends on cdt_pkg and the countdown_timer_with_overtime RTL.
module countdown_timer_with_overtime_tb;
  import cdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int OVERTIME_MAX  = 359999;
  localparam int THIN_AT       = -600;
  localparam int SOAK_TICKS    = -THIN_AT + 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN, OP_CALM} op_kind_t;

  typedef struct {
    op_kind_t             kind;
    in_item_t             item;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } timer_op_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  timer_op_t pending_ops[$];
  out_item_t expected_displays[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  logic      calm = 1'b0;

  // predictor state and its copy of the registers
  int                timer_count;
  logic              timer_run;
  logic              timer_thin;
  logic [STEP_W-1:0] step_reg;
  logic [SETV_W-1:0] max_reg;

  countdown_timer_with_overtime uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // apply one event to the timer and build the display it produces
  function automatic out_item_t advance_timer(in_item_t ev);
    int        cap;
    int        sum;
    int        mag;
    out_item_t disp;
    cap = (max_reg < SET_CEILING) ? int'(max_reg) : int'(SET_CEILING);
    disp = '0;
    case (ev.func)
      FUNC_TICK: begin
        if (timer_run) begin
          if (timer_count > -OVERTIME_MAX) timer_count--;
          disp.alarm = (timer_count == 0);
        end
      end
      FUNC_PLUS: begin
        if (!timer_run) begin
          sum = timer_count + int'(step_reg);
          timer_count = (sum > cap) ? cap : sum;
        end
      end
      FUNC_MINUS: begin
        if (!timer_run) begin
          sum = timer_count - int'(step_reg);
          timer_count = (sum < 0) ? 0 : sum;
        end
      end
      FUNC_START: begin
        if (timer_count != 0) begin
          timer_run = !timer_run;
          disp.accepted = 1'b1;
        end
      end
      FUNC_HOLD: begin
        if (timer_run || timer_count != 0) begin
          timer_count = 0;
          timer_run = 1'b0;
          timer_thin = 1'b0;
          disp.accepted = 1'b1;
        end
      end
      FUNC_SET: begin
        sum = int'(ev.set_value);
        timer_count = (sum > cap) ? cap : sum;
      end
      default: ;
    endcase
    if (timer_count <= THIN_AT) timer_thin = 1'b1;
    // digit groups: plain count, or overtime magnitude with sign format
    if (timer_count >= 0) begin
      disp.format = FMT_MSS;
      disp.minutes = MINUTES_W'(timer_count / 60);
      disp.seconds_shown = SECS_W'(timer_count % 60);
    end else begin
      mag = -timer_count;
      disp.seconds_shown = SECS_W'(mag % 60);
      if (mag >= 3600) begin
        disp.format = FMT_PHMS;
        disp.hours = HOURS_W'(mag / 3600);
        disp.minutes = MINUTES_W'((mag % 3600) / 60);
      end else begin
        disp.format = (mag >= 600) ? FMT_PMM : FMT_PMSS;
        disp.minutes = MINUTES_W'(mag / 60);
      end
    end
    disp.running = timer_run;
    disp.thin_font = timer_thin;
    return disp;
  endfunction

  task automatic push_item(logic [FUNC_W-1:0] f, logic [SETV_W-1:0] v);
    timer_op_t op;
    op.kind = OP_ITEM;
    op.item.func = f;
    op.item.set_value = v;
    op.idx = '0;
    op.data = '0;
    pending_ops.push_back(op);
  endtask

  task automatic push_ctrl(op_kind_t k, logic [CFG_IDX_W-1:0] i, logic [CFG_DAT_W-1:0] d);
    timer_op_t op;
    op.kind = k;
    op.item = '0;
    op.idx = i;
    op.data = d;
    pending_ops.push_back(op);
  endtask

  // one well-formed use: set, adjust, start, count down, maybe pause, finish
  task automatic add_timer_run();
    int ticks;
    push_item(FUNC_SET, ($urandom_range(0, 3) == 0) ? SETV_W'($urandom_range(0, 8191))
                                                    : SETV_W'($urandom_range(0, 150)));
    repeat ($urandom_range(0, 3))
      push_item($urandom_range(0, 1) ? FUNC_PLUS : FUNC_MINUS, SETV_W'($urandom));
    push_item(FUNC_START, SETV_W'($urandom));
    ticks = $urandom_range(0, 120);
    for (int i = 0; i < ticks; i++) begin
      push_item(FUNC_TICK, SETV_W'($urandom));
      if ($urandom_range(0, 39) == 0) begin
        push_item(FUNC_START, SETV_W'($urandom));
        if ($urandom_range(0, 1))
          push_item($urandom_range(0, 1) ? FUNC_PLUS : FUNC_MINUS, SETV_W'($urandom));
        push_item(FUNC_START, SETV_W'($urandom));
      end
    end
    case ($urandom_range(0, 3))
      0: push_item(FUNC_HOLD, SETV_W'($urandom));
      1: push_item(FUNC_START, SETV_W'($urandom));
      2: push_item(FUNC_SET, SETV_W'($urandom));
      default: ;
    endcase
  endtask

  // mostly well-formed runs, some raw noise including unused codes
  task automatic add_random_phase(int n_items);
    int stop_at;
    stop_at = pending_ops.size() + n_items;
    while (pending_ops.size() < stop_at) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5))
          push_item(FUNC_W'($urandom_range(0, 7)), SETV_W'($urandom));
      else
        add_timer_run();
    end
  endtask

  task automatic add_config(logic [CFG_DAT_W-1:0] step_val, logic [CFG_DAT_W-1:0] max_val);
    push_ctrl(OP_CFG, CFG_STEP, step_val);
    push_ctrl(OP_CFG, CFG_MAX, max_val);
  endtask

  // driver: feeds events and register writes, predicts on each transfer
  int   gap_left;
  int   gap_odds;
  int   quiet_cycles;
  int   sent_count;
  logic load_in;
  logic load_cfg;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      calm <= 1'b0;
      gap_left = 0;
      gap_odds = 2;
      quiet_cycles = 0;
      sent_count = 0;
      timer_count = 0;
      timer_run = 1'b0;
      timer_thin = 1'b0;
      step_reg = STEP_RESET;
      max_reg = SET_CEILING;
    end else begin
      load_in = in_valid;
      load_cfg = cfg_valid;
      // retire completed transfers
      if (in_valid && in_ready) begin
        expected_displays.push_back(advance_timer(in_data));
        load_in = 1'b0;
        sent_count++;
        if (sent_count % 128 == 0) gap_odds = $urandom_range(0, 3);
        if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds)
          gap_left = $urandom_range(1, 14);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP: step_reg = cfg_data[STEP_W-1:0];
          CFG_MAX:  max_reg = cfg_data;
          default: ;
        endcase
        load_cfg = 1'b0;
      end
      if (expected_displays.size() == 0 && !load_in) quiet_cycles++;
      else quiet_cycles = 0;
      // pick up the next pending entry
      if (!load_in && !load_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          case (pending_ops[0].kind)
            OP_ITEM: begin
              in_data <= pending_ops[0].item;
              load_in = 1'b1;
              void'(pending_ops.pop_front());
            end
            OP_CALM: begin
              calm <= 1'b1;
              void'(pending_ops.pop_front());
            end
            OP_CFG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                cfg_index <= pending_ops[0].idx;
                cfg_data <= pending_ops[0].data;
                load_cfg = 1'b1;
                void'(pending_ops.pop_front());
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      in_valid <= load_in;
      cfg_valid <= load_cfg;
    end
  end

  // monitor: checks each result transfer and stalls the result side
  int        stall_left;
  int        stall_odds;
  int        mon_cycles;
  logic      take;
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      stall_odds = 2;
      mon_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_displays.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %p", out_data);
        end else begin
          want = expected_displays.pop_front();
          if (out_data.accepted !== want.accepted || out_data.running !== want.running ||
              out_data.alarm !== want.alarm || out_data.format !== want.format ||
              out_data.hours !== want.hours || out_data.minutes !== want.minutes ||
              out_data.seconds_shown !== want.seconds_shown ||
              out_data.thin_font !== want.thin_font) begin
            fail_count++;
            if (fail_count <= 10)
              $display("display mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      mon_cycles++;
      if (mon_cycles % 256 == 0) stall_odds = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, 8) <= stall_odds) begin
        stall_left = $urandom_range(0, 13);
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ready <= take;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("countdown_timer_with_overtime test failed");
      $finish;
    end
  end

  initial begin
    // directed: reset registers, refusals, clamps, alarm, overtime pause
    push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_HOLD, '0);
    push_item(FUNC_MINUS, '0);
    push_item(FUNC_PLUS, '0);
    push_item(FUNC_W'(6), 13'h1fff);
    push_item(FUNC_W'(7), '0);
    push_item(FUNC_SET, 13'h1fff);
    push_item(FUNC_PLUS, '0);
    push_item(FUNC_SET, 13'd3);
    push_item(FUNC_START, '0);
    push_item(FUNC_PLUS, '0);
    push_item(FUNC_MINUS, '0);
    repeat (3) push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_MINUS, '0);
    push_item(FUNC_SET, 13'd2);
    push_item(FUNC_START, '0);
    push_item(FUNC_SET, 13'd4096);
    push_item(FUNC_HOLD, '0);

    // zero step and a ceiling register above the hard limit
    add_config('0, 13'h1fff);
    push_item(FUNC_SET, 13'd40);
    push_item(FUNC_PLUS, '0);
    push_item(FUNC_MINUS, '0);
    add_random_phase(200);
    // smallest step, ceiling of zero
    add_config(13'd1, '0);
    add_random_phase(200);
    // largest listed step, leaving a count above the next ceiling
    add_config(13'd3600, 13'd5999);
    add_random_phase(200);
    push_item(FUNC_HOLD, '0);
    push_item(FUNC_SET, 13'd5000);
    // step write with bit 12 set, low ceiling
    add_config(13'h1007, 13'd100);
    push_item(FUNC_PLUS, '0);
    add_random_phase(200);
    // random setting, full 12-bit step, unused register index
    add_config(CFG_DAT_W'($urandom_range(1, 4095)), CFG_DAT_W'($urandom_range(0, 8191)));
    push_ctrl(OP_CFG, CFG_UNUSED, CFG_DAT_W'($urandom));
    push_ctrl(OP_CFG, CFG_STEP, 13'd4095);
    add_random_phase(200);
    // back to reset values, with one full drain in the middle
    add_config(13'd30, 13'd5999);
    add_random_phase(100);
    push_ctrl(OP_DRAIN, '0, '0);
    add_random_phase(100);

    // last part without idling: run into overtime past the thin-font point,
    // then pause, clear in overtime and hold to drop the thin font
    push_ctrl(OP_CALM, '0, '0);
    push_item(FUNC_HOLD, '0);
    push_item(FUNC_SET, 13'd1);
    push_item(FUNC_START, '0);
    repeat (SOAK_TICKS) push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_TICK, '0);
    push_item(FUNC_START, '0);
    push_item(FUNC_MINUS, '0);
    push_item(FUNC_HOLD, '0);
    push_item(FUNC_SET, 13'd10);
    push_item(FUNC_HOLD, '0);
    push_item(FUNC_TICK, '0);

    // reset, then wait for all transfers and results
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (pending_ops.size() != 0 || in_valid || cfg_valid);
    do @(negedge clk); while (expected_displays.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_displays.size() == 0) begin
      $display("countdown_timer_with_overtime test passed");
    end else begin
      $display("countdown_timer_with_overtime test failed");
    end
    $finish;
  end

endmodule
